### rtl/core/abcs_pkg.sv
// ----------------------------------------------------------------------------
// abcs_pkg: shared types and constants of the alternating-bit chunk sender
// Holds the request and operation codes, the sender states, the register
// indexes, the queue entry type and the sizing constants.
// ----------------------------------------------------------------------------
package abcs_pkg;

    // Message buffer and chunk sizing.
    localparam int MSG_BYTES   = 256;
    localparam int MSG_AW      = $clog2(MSG_BYTES);
    localparam int MAX_CHUNK   = 64;
    localparam int CHUNK_W     = 7;
    localparam int WAIT_W      = 17;
    localparam int CFG_W       = 16;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_W-1:0] DEFAULT_WAIT = 16'd80;

    // Request codes as they arrive on req_type.
    localparam logic [2:0] REQ_LOAD    = 3'd0;
    localparam logic [2:0] REQ_START   = 3'd1;
    localparam logic [2:0] REQ_PAYLOAD = 3'd2;
    localparam logic [2:0] REQ_CONFIRM = 3'd3;
    localparam logic [2:0] REQ_RESET   = 3'd4;

    // Configuration register indexes.
    typedef logic [0:0] cfg_idx_t;
    localparam cfg_idx_t REG_MAX_PKG_IDX = 1'd0;
    localparam cfg_idx_t REG_MAX_WAIT    = 1'd1;

    typedef enum logic [2:0] {
        OP_LOAD,
        OP_START,
        OP_PAYLOAD,
        OP_CONFIRM,
        OP_RESET,
        OP_NONE
    } op_t;

    typedef enum logic [2:0] {
        SND_IDLE,
        SND_PENDING,
        SND_SENDING,
        SND_WAITNEXT,
        SND_RESYNC,
        SND_RESYNC_SEND
    } snd_state_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_EXEC,
        PH_STREAM
    } phase_t;

    typedef struct packed {
        op_t                op;
        logic [7:0]         byte_index;
        logic [7:0]         byte_value;
        logic [7:0]         msg_length;
        logic [CHUNK_W-1:0] max_len;
        logic               confirm_value;
    } item_t;

    // Head of the queue as seen by the back.
    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

endpackage

### rtl/core/abcs_ram.sv
// ----------------------------------------------------------------------------
// abcs_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module abcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/abcs_front.sv
// ----------------------------------------------------------------------------
// abcs_front: request intake and classification
// Decodes each accepted request into an operation, clamps the chunk size
// and holds it in a short queue until the back takes it.
// ----------------------------------------------------------------------------
module abcs_front
    import abcs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         req_type,
    input  logic [7:0]         byte_index,
    input  logic [7:0]         byte_value,
    input  logic [7:0]         msg_length,
    input  logic [CHUNK_W-1:0] max_len,
    input  logic               confirm_value,
    input  logic               pop,
    output queue_head_t        head
);

    item_t               entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    item_t               item_in;
    logic                push;
    logic                do_pop;

    // Classify the request and clamp the chunk size once, at the door.
    always_comb
    begin
        item_in.byte_index    = byte_index;
        item_in.byte_value    = byte_value;
        item_in.msg_length    = msg_length;
        item_in.confirm_value = confirm_value;
        item_in.max_len       = (max_len > CHUNK_W'(MAX_CHUNK)) ? CHUNK_W'(MAX_CHUNK) : max_len;
        case (req_type)
            REQ_LOAD:    item_in.op = OP_LOAD;
            REQ_START:   item_in.op = OP_START;
            REQ_PAYLOAD: item_in.op = OP_PAYLOAD;
            REQ_CONFIRM: item_in.op = OP_CONFIRM;
            REQ_RESET:   item_in.op = OP_RESET;
            default:     item_in.op = OP_NONE;
        endcase
    end

    assign busy   = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign push   = start && !busy;
    assign do_pop = pop && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= item_in;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.item  = entry_reg[rd_ptr_reg];

endmodule

### rtl/core/abcs_back.sv
// ----------------------------------------------------------------------------
// abcs_back: sender state machine and result generation
// Takes one operation at a time from the queue, updates the sender state
// and streams chunk bytes out of the message buffer, one per cycle.
// ----------------------------------------------------------------------------
module abcs_back
    import abcs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  queue_head_t      head,
    output logic             pop,
    input  logic             cfg_we,
    input  cfg_idx_t         cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata,
    output logic             result_valid,
    output logic [7:0]       package_index,
    output logic [7:0]       payload_byte,
    output logic             byte_valid,
    output logic             last,
    output logic             active
);

    phase_t             phase_reg, phase_next;
    item_t              item_reg, item_next;
    snd_state_t         snd_reg, snd_next;
    logic [7:0]         msg_len_reg, msg_len_next;
    logic [7:0]         offset_reg, offset_next;
    logic [7:0]         pkg_cnt_reg, pkg_cnt_next;
    logic               exp_reg, exp_next;
    logic [WAIT_W-1:0]  wait_reg, wait_next;
    logic [CHUNK_W-1:0] blp_reg, blp_next;
    logic [CHUNK_W-1:0] k_reg, k_next;
    logic [7:0]         stream_pkg_reg, stream_pkg_next;
    logic [7:0]         max_pkg_reg, max_pkg_next;
    logic [CFG_W-1:0]   max_wait_reg, max_wait_next;

    logic               res_valid_reg, res_valid_next;
    logic [7:0]         res_pkg_reg, res_pkg_next;
    logic               res_bvalid_reg, res_bvalid_next;
    logic               res_last_reg, res_last_next;
    logic               res_active_reg, res_active_next;
    logic               res_inrange_reg, res_inrange_next;

    logic               ram_we;
    logic [MSG_AW-1:0]  ram_raddr;
    logic [7:0]         ram_rdata;

    logic [7:0]         diff;
    logic [7:0]         n8;
    logic [CHUNK_W-1:0] n;
    logic [8:0]         chunk_end;
    logic [8:0]         rd_sum;
    logic [WAIT_W-1:0]  wait_inc;
    logic [7:0]         pay_pkg;

    always_comb
    begin
        phase_next       = phase_reg;
        item_next        = item_reg;
        snd_next         = snd_reg;
        msg_len_next     = msg_len_reg;
        offset_next      = offset_reg;
        pkg_cnt_next     = pkg_cnt_reg;
        exp_next         = exp_reg;
        wait_next        = wait_reg;
        blp_next         = blp_reg;
        k_next           = k_reg;
        stream_pkg_next  = stream_pkg_reg;
        max_pkg_next     = max_pkg_reg;
        max_wait_next    = max_wait_reg;
        res_valid_next   = 1'b0;
        res_pkg_next     = res_pkg_reg;
        res_bvalid_next  = 1'b0;
        res_last_next    = 1'b0;
        res_active_next  = res_active_reg;
        res_inrange_next = 1'b0;
        pop              = 1'b0;
        ram_we           = 1'b0;

        diff      = item_reg.msg_length;
        diff      = msg_len_reg - offset_reg;
        n8        = (diff > 8'(item_reg.max_len)) ? 8'(item_reg.max_len) : diff;
        n         = CHUNK_W'(n8);
        chunk_end = {1'b0, offset_reg} + 9'(n);
        wait_inc  = wait_reg + 1'b1;
        rd_sum    = {1'b0, offset_reg} + 9'(k_reg);
        ram_raddr = rd_sum[MSG_AW-1:0];
        pay_pkg   = 8'd0;

        case (phase_reg)
            PH_IDLE:
            begin
                if (head.valid)
                begin
                    pop        = 1'b1;
                    item_next  = head.item;
                    phase_next = PH_EXEC;
                end
            end

            PH_EXEC:
            begin
                phase_next = PH_IDLE;
                case (item_reg.op)
                    OP_LOAD:
                    begin
                        ram_we = (32'(item_reg.byte_index) < MSG_BYTES);
                    end
                    OP_START:
                    begin
                        msg_len_next = item_reg.msg_length;
                        offset_next  = 8'd0;
                        pkg_cnt_next = 8'd1;
                        wait_next    = '0;
                        snd_next     = (snd_reg == SND_IDLE) ? SND_PENDING : SND_RESYNC_SEND;
                    end
                    OP_PAYLOAD:
                    begin
                        blp_next = '0;
                        case (snd_reg)
                            SND_RESYNC, SND_RESYNC_SEND:
                            begin
                                pay_pkg = max_pkg_reg;
                            end
                            SND_PENDING, SND_SENDING:
                            begin
                                snd_next = SND_SENDING;
                                blp_next = n;
                                if (pkg_cnt_reg > 8'd1 && chunk_end >= {1'b0, msg_len_reg})
                                begin
                                    pay_pkg = 8'd0;
                                end
                                else
                                begin
                                    pay_pkg = pkg_cnt_reg;
                                end
                            end
                            default:
                            begin
                                pay_pkg = 8'd0;
                            end
                        endcase
                        if ((snd_reg == SND_PENDING || snd_reg == SND_SENDING) && n != '0)
                        begin
                            phase_next      = PH_STREAM;
                            k_next          = '0;
                            stream_pkg_next = pay_pkg;
                        end
                    end
                    OP_CONFIRM:
                    begin
                        case (snd_reg)
                            SND_SENDING:
                            begin
                                if (item_reg.confirm_value != exp_reg)
                                begin
                                    wait_next = wait_inc;
                                    if (wait_inc > {1'b0, max_wait_reg})
                                    begin
                                        exp_next = ~item_reg.confirm_value;
                                        snd_next = SND_RESYNC;
                                    end
                                end
                                else
                                begin
                                    offset_next = offset_reg + 8'(blp_reg);
                                    if (offset_next >= msg_len_reg)
                                    begin
                                        snd_next = (pkg_cnt_reg == 8'd1) ? SND_WAITNEXT : SND_IDLE;
                                    end
                                    pkg_cnt_next = pkg_cnt_reg + 8'd1;
                                    exp_next     = ~exp_reg;
                                    wait_next    = '0;
                                end
                            end
                            SND_RESYNC, SND_RESYNC_SEND, SND_WAITNEXT:
                            begin
                                if (item_reg.confirm_value == exp_reg)
                                begin
                                    snd_next = (snd_reg == SND_RESYNC_SEND) ? SND_SENDING : SND_IDLE;
                                    exp_next = ~item_reg.confirm_value;
                                end
                                else if (snd_reg == SND_WAITNEXT)
                                begin
                                    wait_next = wait_inc;
                                    if (wait_inc > {1'b0, max_wait_reg})
                                    begin
                                        exp_next = ~item_reg.confirm_value;
                                        snd_next = SND_RESYNC;
                                    end
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                    OP_RESET:
                    begin
                        blp_next      = '0;
                        offset_next   = 8'd0;
                        pkg_cnt_next  = 8'd1;
                        exp_next      = 1'b1;
                        wait_next     = '0;
                        max_wait_next = DEFAULT_WAIT;
                        snd_next      = SND_IDLE;
                    end
                    default:
                    begin
                    end
                endcase

                // Every operation that does not stream bytes gives one plain result.
                if (phase_next != PH_STREAM)
                begin
                    res_valid_next  = 1'b1;
                    res_last_next   = 1'b1;
                    res_pkg_next    = (item_reg.op == OP_PAYLOAD) ? pay_pkg : 8'd0;
                    res_active_next = (snd_next != SND_IDLE);
                end
            end

            PH_STREAM:
            begin
                res_valid_next   = 1'b1;
                res_bvalid_next  = 1'b1;
                res_pkg_next     = stream_pkg_reg;
                res_active_next  = (snd_reg != SND_IDLE);
                res_inrange_next = (32'(rd_sum) < MSG_BYTES);
                res_last_next    = ((k_reg + 1'b1) == blp_reg);
                k_next           = k_reg + 1'b1;
                if (res_last_next)
                begin
                    phase_next = PH_IDLE;
                end
            end

            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        // The user must write registers only while no request is in flight; not enforced.
        if (cfg_we)
        begin
            case (cfg_index)
                REG_MAX_PKG_IDX:
                begin
                    if (cfg_wdata[7:0] != max_pkg_reg)
                    begin
                        max_pkg_next  = cfg_wdata[7:0];
                        blp_next      = '0;
                        offset_next   = 8'd0;
                        pkg_cnt_next  = 8'd1;
                        exp_next      = 1'b1;
                        wait_next     = '0;
                        max_wait_next = DEFAULT_WAIT;
                        snd_next      = SND_IDLE;
                    end
                end
                REG_MAX_WAIT:
                begin
                    max_wait_next = cfg_wdata;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            snd_reg        <= SND_IDLE;
            msg_len_reg    <= 8'd0;
            offset_reg     <= 8'd0;
            pkg_cnt_reg    <= 8'd1;
            exp_reg        <= 1'b1;
            wait_reg       <= '0;
            blp_reg        <= '0;
            k_reg          <= '0;
            max_pkg_reg    <= 8'd0;
            max_wait_reg   <= DEFAULT_WAIT;
            res_valid_reg  <= 1'b0;
            res_bvalid_reg <= 1'b0;
            res_last_reg   <= 1'b0;
            res_active_reg <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            snd_reg        <= snd_next;
            msg_len_reg    <= msg_len_next;
            offset_reg     <= offset_next;
            pkg_cnt_reg    <= pkg_cnt_next;
            exp_reg        <= exp_next;
            wait_reg       <= wait_next;
            blp_reg        <= blp_next;
            k_reg          <= k_next;
            max_pkg_reg    <= max_pkg_next;
            max_wait_reg   <= max_wait_next;
            res_valid_reg  <= res_valid_next;
            res_bvalid_reg <= res_bvalid_next;
            res_last_reg   <= res_last_next;
            res_active_reg <= res_active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg        <= item_next;
        stream_pkg_reg  <= stream_pkg_next;
        res_pkg_reg     <= res_pkg_next;
        res_inrange_reg <= res_inrange_next;
    end

    abcs_ram #(
        .WIDTH (8),
        .DEPTH (MSG_BYTES)
    ) u_msg_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (item_reg.byte_index[MSG_AW-1:0]),
        .wdata (item_reg.byte_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign result_valid  = res_valid_reg;
    assign package_index = res_pkg_reg;
    assign byte_valid    = res_bvalid_reg;
    assign last          = res_last_reg;
    assign active        = res_active_reg;
    assign payload_byte  = (res_bvalid_reg && res_inrange_reg) ? ram_rdata : 8'd0;

endmodule

### rtl/core/alternating_bit_chunk_sender_top.sv
// ----------------------------------------------------------------------------
// alternating_bit_chunk_sender_top: stop-and-wait chunk sender
// Stores a message and hands it out in chunks tagged with a package index,
// tracking an alternating confirm bit and resyncing after missed confirms.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Results come out
// one per cycle on result_valid and cannot be held off, so the receiver must
// take every transfer in the cycle it appears. A request that gives one
// result (load, start, confirm, reset, an empty payload or an unused code)
// occupies the back end for a pop and an execute step; a payload request
// that yields n chunk bytes then streams them from the single-read-port
// message RAM one address per cycle. When the block is empty, a request
// passes the queue, the pop and the execute step before its result is
// registered, and a first chunk byte also passes the stream step.
// A two-entry queue sits between intake and execution, so busy rises only
// when two requests are waiting. Every request ends with a result whose
// last flag is high. Buffer entries that were never loaded read back as
// arbitrary data. Configuration writes are taken at any edge where cfg_we
// is high and must only be issued while no request is in flight; writing a
// new max_package_index value also resets the sender state and restores the
// wait limit to 80.
// ----------------------------------------------------------------------------
module alternating_bit_chunk_sender_top
    import abcs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         req_type,
    input  logic [7:0]         byte_index,
    input  logic [7:0]         byte_value,
    input  logic [7:0]         msg_length,
    input  logic [CHUNK_W-1:0] max_len,
    input  logic               confirm_value,
    input  logic               cfg_we,
    input  cfg_idx_t           cfg_index,
    input  logic [CFG_W-1:0]   cfg_wdata,
    output logic               result_valid,
    output logic [7:0]         package_index,
    output logic [7:0]         payload_byte,
    output logic               byte_valid,
    output logic               last,
    output logic               active
);

    queue_head_t head;
    logic        pop;

    // Intake: decodes each request and queues it for execution.
    abcs_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .byte_index    (byte_index),
        .byte_value    (byte_value),
        .msg_length    (msg_length),
        .max_len       (max_len),
        .confirm_value (confirm_value),
        .pop           (pop),
        .head          (head)
    );

    // Execution: sender state machine, message RAM and result registers.
    abcs_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .pop           (pop),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .result_valid  (result_valid),
        .package_index (package_index),
        .payload_byte  (payload_byte),
        .byte_valid    (byte_valid),
        .last          (last),
        .active        (active)
    );

    // A chunk streams without gaps until its last byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && byte_valid && !last) |=> (result_valid && byte_valid))
    else $error("chunk stream broke before its last byte");

    // A result without a chunk byte is always the only result of its request.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !byte_valid) |-> (last && payload_byte == 8'd0))
    else $error("plain result not marked last or carries a byte");

    // Chunk bytes are only sent while the sender is busy with a message.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && byte_valid) |-> active)
    else $error("chunk byte sent while the sender is idle");

    // A full queue always has a valid head.
    assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> head.valid)
    else $error("busy with an empty queue");

endmodule

### verif/alternating_bit_chunk_sender_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alternating_bit_chunk_sender_top_tb: self-checking bench of the chunk sender
// Drives load, start, payload, confirm and reset requests through the command
// port, keeps a cycle-free model of the sender state machine and checks every
// result transfer field by field against the model's prediction.
// ----------------------------------------------------------------------------
module alternating_bit_chunk_sender_top_tb;
    import abcs_pkg::*;

    // Request codes that the block has no meaning for.
    localparam logic [2:0] REQ_SPARE_LO = 3'd5;
    localparam logic [2:0] REQ_SPARE_HI = 3'd7;

    // Cycles without any transfer before the run is declared hung. A full
    // 64-byte chunk keeps result_valid busy, so only sender gaps and the
    // block's own pop and execute steps count toward this.
    localparam int STALL_LIMIT  = 4000;
    // Cycles allowed after the last expected result before the block is
    // taken to be quiet again.
    localparam int DRAIN_CYCLES = 10;
    localparam int PRINT_CAP    = 40;
    localparam int PHASE_ITEMS  = 10;
    localparam int DIR_ROWS     = 25;
    // Buffer entries loaded before the random part; no message is longer.
    localparam int FILL_BYTES   = 32;

    // One request as the bench sees it.
    typedef struct packed {
        logic [2:0]         kind;
        logic [7:0]         pos;
        logic [7:0]         val;
        logic [7:0]         len;
        logic [CHUNK_W-1:0] room;
        logic               bit_in;
    } tx_req_t;

    // One result transfer.
    typedef struct packed {
        logic [7:0] pkg;
        logic [7:0] data;
        logic       vld;
        logic       lst;
        logic       act;
    } chunk_res_t;

    // A directed row; when typed is set, res is the whole expected answer.
    typedef struct {
        tx_req_t    rq;
        bit         typed;
        chunk_res_t res;
    } dir_row_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic [2:0]       req_type = REQ_LOAD;
    logic [7:0]       byte_index = 8'h00;
    logic [7:0]       byte_value = 8'h00;
    logic [7:0]       msg_length = 8'h00;
    logic [CHUNK_W-1:0] max_len = '0;
    logic             confirm_value = 1'b0;
    logic             cfg_we = 1'b0;
    cfg_idx_t         cfg_index = REG_MAX_PKG_IDX;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic             result_valid;
    logic [7:0]       package_index;
    logic [7:0]       payload_byte;
    logic             byte_valid;
    logic             last;
    logic             active;

    always #5 clk = ~clk;

    alternating_bit_chunk_sender_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .byte_index   (byte_index),
        .byte_value   (byte_value),
        .msg_length   (msg_length),
        .max_len      (max_len),
        .confirm_value(confirm_value),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .result_valid (result_valid),
        .package_index(package_index),
        .payload_byte (payload_byte),
        .byte_valid   (byte_valid),
        .last         (last),
        .active       (active)
    );

    // ------------------------------------------------------------------
    // Sender model. It mirrors the block's state and is advanced once per
    // accepted request, at the edge of the transfer.
    // ------------------------------------------------------------------
    snd_state_t         snd_st;
    logic [7:0]         msg_mem [MSG_BYTES];
    logic [7:0]         msg_len;
    logic [7:0]         send_off;
    logic [7:0]         pkg_cnt;
    logic [7:0]         resync_idx;
    logic               want_bit;
    logic [WAIT_W-1:0]  miss_cnt;
    logic [CHUNK_W-1:0] chunk_bytes;
    logic [CFG_W-1:0]   wait_limit;

    chunk_res_t pending_res[$];   // results still owed by the block, oldest first
    chunk_res_t step_res[$];      // results of the request just modeled

    int errors      = 0;
    int items_sent  = 0;
    int gap_pct     = 0;
    int stall_cycles = 0;

    dir_row_t dir_tab [DIR_ROWS];

    // A state reset keeps the buffer, the message length and the resync index,
    // but puts the wait limit back to its default.
    function automatic void clear_sender();
        chunk_bytes = '0;
        send_off    = 8'h00;
        pkg_cnt     = 8'h01;
        want_bit    = 1'b1;
        miss_cnt    = '0;
        wait_limit  = DEFAULT_WAIT;
        snd_st      = SND_IDLE;
    endfunction

    // A wrong confirm bit; too many in a row force a resync that expects the
    // opposite of the bit just seen.
    function automatic void note_miss(logic v);
        miss_cnt = miss_cnt + 1'b1;
        if (miss_cnt > {1'b0, wait_limit})
        begin
            want_bit = ~v;
            snd_st   = SND_RESYNC;
        end
    endfunction

    function automatic void take_confirm(logic v);
        case (snd_st)
            SND_SENDING:
            begin
                if (v != want_bit)
                begin
                    note_miss(v);
                end
                else
                begin
                    send_off = send_off + 8'(chunk_bytes);
                    if (send_off >= msg_len)
                        snd_st = (pkg_cnt == 8'd1) ? SND_WAITNEXT : SND_IDLE;
                    pkg_cnt  = pkg_cnt + 8'd1;
                    want_bit = ~want_bit;
                    miss_cnt = '0;
                end
            end
            SND_RESYNC, SND_RESYNC_SEND, SND_WAITNEXT:
            begin
                if (v == want_bit)
                begin
                    snd_st   = (snd_st == SND_RESYNC_SEND) ? SND_SENDING : SND_IDLE;
                    want_bit = ~v;
                end
                else if (snd_st == SND_WAITNEXT)
                begin
                    note_miss(v);
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    // Works out the results of one request into step_res and advances the model.
    function automatic void predict_item(tx_req_t rq);
        logic [CHUNK_W-1:0] room;
        logic [7:0]         n;
        logic [7:0]         pkg;
        int                 k;
        step_res.delete();
        pkg = 8'h00;
        case (rq.kind)
            REQ_LOAD:
                msg_mem[rq.pos] = rq.val;
            REQ_START:
            begin
                msg_len  = rq.len;
                send_off = 8'h00;
                pkg_cnt  = 8'h01;
                miss_cnt = '0;
                snd_st   = (snd_st == SND_IDLE) ? SND_PENDING : SND_RESYNC_SEND;
            end
            REQ_PAYLOAD:
            begin
                room = (rq.room > MAX_CHUNK) ? CHUNK_W'(MAX_CHUNK) : rq.room;
                chunk_bytes = '0;
                case (snd_st)
                    SND_RESYNC, SND_RESYNC_SEND:
                        pkg = resync_idx;
                    SND_PENDING, SND_SENDING:
                    begin
                        snd_st = SND_SENDING;
                        n = msg_len - send_off;
                        if (n > room)
                            n = room;
                        chunk_bytes = n[CHUNK_W-1:0];
                        // The final chunk carries index 0, except while the
                        // counter itself reads 0 or 1.
                        if (pkg_cnt > 8'd1 && {1'b0, send_off} + {1'b0, n} >= {1'b0, msg_len})
                            pkg = 8'h00;
                        else
                            pkg = pkg_cnt;
                    end
                    default:
                        pkg = 8'h00;
                endcase
                if (chunk_bytes == 0)
                begin
                    step_res.push_back(chunk_res_t'({pkg, 8'h00, 1'b0, 1'b1,
                                                     snd_st != SND_IDLE}));
                end
                else
                begin
                    // Positions past the end of the buffer read as zero.
                    for (k = 0; k < chunk_bytes; k++)
                        step_res.push_back(chunk_res_t'({pkg,
                            ((int'(send_off) + k < MSG_BYTES) ?
                                msg_mem[8'(send_off + k)] : 8'h00),
                            1'b1, k == chunk_bytes - 1, snd_st != SND_IDLE}));
                end
                return;
            end
            REQ_CONFIRM:
                take_confirm(rq.bit_in);
            REQ_RESET:
                clear_sender();
            default:
            begin
            end
        endcase
        step_res.push_back(chunk_res_t'({8'h00, 8'h00, 1'b0, 1'b1, snd_st != SND_IDLE}));
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    function automatic tx_req_t rand_req();
        tx_req_t rq;
        rq.kind   = 3'($urandom_range(7));
        rq.pos    = 8'($urandom_range(255));
        rq.val    = 8'($urandom_range(255));
        rq.len    = 8'($urandom_range(FILL_BYTES));
        rq.room   = CHUNK_W'($urandom_range(127));
        rq.bit_in = 1'($urandom_range(1));
        return rq;
    endfunction

    // Mostly short messages, some medium, a few that span every loaded entry.
    function automatic logic [7:0] pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return 8'($urandom_range(16));
        else if (r < 90)
            return 8'($urandom_range(FILL_BYTES - 1, 17));
        return 8'(FILL_BYTES);
    endfunction

    // Chunk limits: mostly legal, some empty, some beyond the clamp.
    function automatic logic [CHUNK_W-1:0] pick_room();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return CHUNK_W'($urandom_range(MAX_CHUNK, 1));
        else if (r < 80)
            return '0;
        return CHUNK_W'($urandom_range(127, MAX_CHUNK + 1));
    endfunction

    function automatic dir_row_t mk_row(logic [2:0] kind, logic [7:0] pos, logic [7:0] val,
                                        logic [7:0] len, logic [CHUNK_W-1:0] room,
                                        logic b, bit typed, logic [7:0] pkg, logic act);
        dir_row_t row;
        row.rq    = '{kind: kind, pos: pos, val: val, len: len, room: room, bit_in: b};
        row.typed = typed;
        row.res   = chunk_res_t'({pkg, 8'h00, 1'b0, 1'b1, act});
        return row;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] want_v,
                                   input logic [7:0] got_v);
        errors++;
        if (errors <= PRINT_CAP)
            $display("t=%0t: %s expected %0d got %0d", $time, what, want_v, got_v);
    endtask

    // Offers one request and returns at the edge that takes it. The start
    // line stays high on return so that a back-to-back request needs no
    // second assignment in the same step.
    task automatic send_item(input tx_req_t rq, input bit typed, input chunk_res_t typed_res);
        int gap;
        gap = 0;
        while ($urandom_range(99) < gap_pct)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start         <= 1'b1;
        req_type      <= rq.kind;
        byte_index    <= rq.pos;
        byte_value    <= rq.val;
        msg_length    <= rq.len;
        max_len       <= rq.room;
        confirm_value <= rq.bit_in;
        do
            @(posedge clk);
        while (busy);
        predict_item(rq);
        if (typed)
            pending_res.push_back(typed_res);
        else
            foreach (step_res[i])
                pending_res.push_back(step_res[i]);
        items_sent++;
    endtask

    task automatic send_rand(input tx_req_t rq);
        send_item(rq, 1'b0, '0);
    endtask

    // Drops start and waits until every owed result has come out, then for
    // DRAIN_CYCLES more so that the back end can settle.
    task automatic wait_quiet();
        start <= 1'b0;
        while (pending_res.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes both registers, the resync index first since a change of it
    // restores the default wait limit.
    task automatic write_regs(input logic [CFG_W-1:0] idx_word,
                              input logic [CFG_W-1:0] wait_word);
        wait_quiet();
        cfg_we    <= 1'b1;
        cfg_index <= REG_MAX_PKG_IDX;
        cfg_wdata <= idx_word;
        @(posedge clk);
        if (idx_word[7:0] != resync_idx)
        begin
            resync_idx = idx_word[7:0];
            clear_sender();
        end
        cfg_index <= REG_MAX_WAIT;
        cfg_wdata <= wait_word;
        @(posedge clk);
        wait_limit = wait_word;
        cfg_we <= 1'b0;
    endtask

    // A message exchange: up to three loads, a start, then payload and confirm
    // pairs with occasional wrong bits, restarts, resets and stray requests.
    // Fifteen sessions in a hundred are a single random request instead.
    task automatic run_session();
        tx_req_t rq;
        int      steps;
        int      pick;
        if ($urandom_range(99) < 15)
        begin
            send_rand(rand_req());
            return;
        end
        repeat ($urandom_range(3))
        begin
            rq = rand_req();
            rq.kind = REQ_LOAD;
            send_rand(rq);
        end
        rq = rand_req();
        rq.kind = REQ_START;
        rq.len  = pick_length();
        send_rand(rq);
        steps = 0;
        while (snd_st != SND_IDLE && steps < 40)
        begin
            steps++;
            pick = $urandom_range(99);
            rq = rand_req();
            if (pick < 3)
            begin
                rq.kind = REQ_RESET;
                send_rand(rq);
            end
            else if (pick < 8)
            begin
                rq.kind = REQ_START;
                rq.len  = pick_length();
                send_rand(rq);
            end
            else if (pick < 12)
            begin
                send_rand(rq);
            end
            rq = rand_req();
            rq.kind = REQ_PAYLOAD;
            rq.room = pick_room();
            send_rand(rq);
            rq = rand_req();
            rq.kind   = REQ_CONFIRM;
            rq.bit_in = ($urandom_range(99) < 20) ? ~want_bit : want_bit;
            send_rand(rq);
        end
    endtask

    // ------------------------------------------------------------------
    // Result checker. Results cannot be held off, so every cycle with
    // result_valid high is one transfer and must match the oldest owed one.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        chunk_res_t exp_r;
        chunk_res_t obs_r;
        if (rst_n && result_valid)
        begin
            obs_r = chunk_res_t'({package_index, payload_byte, byte_valid, last, active});
            if (pending_res.size() == 0)
            begin
                report_mismatch("result with nothing owed, package_index", 8'h00, obs_r.pkg);
            end
            else
            begin
                exp_r = pending_res.pop_front();
                if (obs_r.pkg != exp_r.pkg)
                    report_mismatch("package_index", exp_r.pkg, obs_r.pkg);
                if (obs_r.data != exp_r.data)
                    report_mismatch("payload_byte", exp_r.data, obs_r.data);
                if (obs_r.vld != exp_r.vld)
                    report_mismatch("byte_valid", 8'(exp_r.vld), 8'(obs_r.vld));
                if (obs_r.lst != exp_r.lst)
                    report_mismatch("last", 8'(exp_r.lst), 8'(obs_r.lst));
                if (obs_r.act != exp_r.act)
                    report_mismatch("active", 8'(exp_r.act), 8'(obs_r.act));
            end
        end
    end

    // Watchdog: any request or result transfer counts as progress.
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("alternating_bit_chunk_sender_top: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial
    begin
        tx_req_t rq;
        int      phase_end;
        resync_idx = 8'h00;
        msg_len    = 8'h00;
        clear_sender();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, default registers. Only buffer entries 0 to 2 and
        // 255 are loaded here, and no message reaches beyond entry 2.
        dir_tab[0]  = mk_row(REQ_CONFIRM, 8'h00, 8'h00, 8'h00, 7'd0, 1'b1, 1, 8'h00, 1'b0);
        dir_tab[1]  = mk_row(REQ_PAYLOAD, 8'h00, 8'h00, 8'h00, 7'd64, 1'b0, 1, 8'h00, 1'b0);
        dir_tab[2]  = mk_row(REQ_LOAD, 8'h00, 8'hFF, 8'h00, 7'd0, 1'b0, 1, 8'h00, 1'b0);
        dir_tab[3]  = mk_row(REQ_LOAD, 8'h01, 8'h00, 8'h00, 7'd0, 1'b0, 1, 8'h00, 1'b0);
        dir_tab[4]  = mk_row(REQ_LOAD, 8'h02, 8'hA5, 8'h00, 7'd0, 1'b0, 0, 8'h00, 1'b0);
        dir_tab[5]  = mk_row(REQ_LOAD, 8'hFF, 8'h5A, 8'h00, 7'd0, 1'b0, 1, 8'h00, 1'b0);
        // Unused codes, one with every other field at its top value, one all zero.
        dir_tab[6]  = mk_row(REQ_SPARE_HI, 8'hFF, 8'hFF, 8'hFF, 7'd127, 1'b1, 1, 8'h00, 1'b0);
        dir_tab[7]  = mk_row(REQ_SPARE_LO, 8'h00, 8'h00, 8'h00, 7'd0, 1'b0, 1, 8'h00, 1'b0);
        dir_tab[8]  = mk_row(REQ_START, 8'h00, 8'h00, 8'd3, 7'd0, 1'b0, 1, 8'h00, 1'b1);
        // A confirm while a send is only pending is ignored.
        dir_tab[9]  = mk_row(REQ_CONFIRM, 8'h00, 8'h00, 8'h00, 7'd0, 1'b0, 1, 8'h00, 1'b1);
        // An empty chunk still reports the package index.
        dir_tab[10] = mk_row(REQ_PAYLOAD, 8'h00, 8'h00, 8'h00, 7'd0, 1'b0, 1, 8'h01, 1'b1);
        dir_tab[11] = mk_row(REQ_PAYLOAD, 8'h00, 8'h00, 8'h00, 7'd2, 1'b0, 0, 8'h00, 1'b0);
        dir_tab[12] = mk_row(REQ_CONFIRM, 8'h00, 8'h00, 8'h00, 7'd0, 1'b0, 0, 8'h00, 1'b0);
        dir_tab[13] = mk_row(REQ_CONFIRM, 8'h00, 8'h00, 8'h00, 7'd0, 1'b1, 0, 8'h00, 1'b0);
        // Oversized chunk limit, clamped; this is the final chunk.
        dir_tab[14] = mk_row(REQ_PAYLOAD, 8'h00, 8'h00, 8'h00, 7'd127, 1'b0, 0, 8'h00, 1'b0);
        dir_tab[15] = mk_row(REQ_CONFIRM, 8'h00, 8'h00, 8'h00, 7'd0, 1'b0, 0, 8'h00, 1'b0);
        // Single-chunk message: after its confirm the sender waits for the next.
        dir_tab[16] = mk_row(REQ_START, 8'h00, 8'h00, 8'd1, 7'd0, 1'b0, 0, 8'h00, 1'b0);
        dir_tab[17] = mk_row(REQ_PAYLOAD, 8'h00, 8'h00, 8'h00, 7'd64, 1'b0, 0, 8'h00, 1'b0);
        dir_tab[18] = mk_row(REQ_CONFIRM, 8'h00, 8'h00, 8'h00, 7'd0, 1'b1, 0, 8'h00, 1'b0);
        dir_tab[19] = mk_row(REQ_PAYLOAD, 8'h00, 8'h00, 8'h00, 7'd8, 1'b0, 0, 8'h00, 1'b0);
        // Start while busy: resync first, then send.
        dir_tab[20] = mk_row(REQ_START, 8'h00, 8'h00, 8'd3, 7'd0, 1'b0, 0, 8'h00, 1'b0);
        dir_tab[21] = mk_row(REQ_PAYLOAD, 8'h00, 8'h00, 8'h00, 7'd8, 1'b0, 0, 8'h00, 1'b0);
        dir_tab[22] = mk_row(REQ_CONFIRM, 8'h00, 8'h00, 8'h00, 7'd0, 1'b0, 0, 8'h00, 1'b0);
        dir_tab[23] = mk_row(REQ_PAYLOAD, 8'h00, 8'h00, 8'h00, 7'd64, 1'b0, 0, 8'h00, 1'b0);
        dir_tab[24] = mk_row(REQ_RESET, 8'h00, 8'h00, 8'h00, 7'd0, 1'b0, 1, 8'h00, 1'b0);

        gap_pct = 22;
        foreach (dir_tab[i])
            send_item(dir_tab[i].rq, dir_tab[i].typed, dir_tab[i].res);

        // Fill the front of the buffer; every message from here on is at
        // most FILL_BYTES long, so it reads only loaded entries.
        for (int i = 0; i < FILL_BYTES; i++)
        begin
            rq = rand_req();
            rq.kind = REQ_LOAD;
            rq.pos  = 8'(i);
            send_rand(rq);
        end

        // Random phases, each under its own register setting: a wait limit
        // of 0 makes every wrong bit resync, the same resync index written
        // twice must not reset the sender, and the largest limit never
        // resyncs.
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:
                begin
                    write_regs({8'($urandom_range(255)), 8'hFF}, 16'h0000);
                    gap_pct = 22;
                end
                1:
                begin
                    write_regs({8'($urandom_range(255)), 8'hFF}, 16'd3);
                    gap_pct = 87;
                end
                2:
                begin
                    write_regs({8'($urandom_range(255)), 8'h00}, 16'hFFFF);
                    gap_pct = 0;
                end
                default:
                begin
                    write_regs({8'($urandom_range(255)), 8'($urandom_range(254, 1))},
                               16'($urandom_range(2)));
                    gap_pct = 0;
                end
            endcase
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
                run_session();
        end

        wait_quiet();
        if (errors == 0)
            $display("alternating_bit_chunk_sender_top: match");
        else
            $display("alternating_bit_chunk_sender_top: mismatch");
        $finish;
    end

endmodule
